// ----- hdl/lzg_pkg.sv -----
// Shared constants, types and a helper function for the lozenge tiling flip engine.
package lzg_pkg;

    localparam int MAX_SIDE   = 256;
    localparam int COORD_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W     = COORD_W + 1;
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int H_W        = 9;
    localparam int TOTAL_W    = 25;
    localparam int COIN_BITS  = 16;
    localparam int THR_W      = 17;
    localparam int ST_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Operation codes of an input word.
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_FLIPPED = 3'd0;
    localparam logic [ST_W-1:0] ST_OUTSIDE = 3'd1;
    localparam logic [ST_W-1:0] ST_LIMIT   = 3'd2;
    localparam logic [ST_W-1:0] ST_BLOCKED = 3'd3;
    localparam logic [ST_W-1:0] ST_CLEARED = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_COL_LO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_COL_HI    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_ROW_LO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_ROW_HI    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_LEVEL    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_THRESHOLD = 3'd7;

    // Height memory read port selection.
    localparam logic [1:0] RD_SITE = 2'd0;
    localparam logic [1:0] RD_NBX  = 2'd1;
    localparam logic [1:0] RD_NBY  = 2'd2;

    typedef struct packed {
        logic [SIDE_W-1:0] grid_side;
        logic [H_W-1:0]    height_limit;
        logic [SIDE_W-1:0] cut_col_lo;
        logic [SIDE_W-1:0] cut_col_hi;
        logic [SIDE_W-1:0] cut_row_lo;
        logic [SIDE_W-1:0] cut_row_hi;
        logic [H_W-1:0]    hole_level;
        logic [THR_W-1:0]  add_threshold;
    } cfg_t;

    typedef struct packed {
        logic       latch_in;
        logic       check;
        logic [1:0] rd_sel;
        logic       lat_h;
        logic       lat_nbx;
        logic       decide;
        logic       clr_start;
        logic       clr_step;
        logic       res_outside;
        logic       res_clear;
        logic       load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic outside;
        logic grid_empty;
        logic sweep_last;
    } dp_status_t;

    function automatic logic in_cut(input logic [SIDE_W-1:0] c, input logic [SIDE_W-1:0] r,
                                    input cfg_t cfg);
        return (c >= cfg.cut_col_lo) && (c < cfg.cut_col_hi)
            && (r >= cfg.cut_row_lo) && (r < cfg.cut_row_hi);
    endfunction

endpackage

// ----- hdl/lzg_ctrl.sv -----
// Flip engine sequencer: step words go through read, decide and write-back; clears sweep.
module lzg_ctrl
    import lzg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       out_stall,
    output logic       out_valid,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_NB1    = 3'd2;
    localparam logic [2:0] S_NB2    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_SITE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.is_clear)
                begin
                    cmd.clr_start = 1'b1;
                    if (status.grid_empty)
                    begin
                        cmd.res_clear = 1'b1;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_CLEAR;
                    end
                end
                else if (status.outside)
                begin
                    cmd.res_outside = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    state_next = S_NB1;
                end
            end
            S_NB1:
            begin
                cmd.lat_h  = 1'b1;
                cmd.rd_sel = RD_NBX;
                state_next = S_NB2;
            end
            S_NB2:
            begin
                cmd.lat_nbx = 1'b1;
                cmd.rd_sel  = RD_NBY;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_FINISH;
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.res_clear = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/lzg_dpath.sv -----
// Datapath of the flip engine: configuration registers, height memory, checks and totals.
module lzg_dpath
    import lzg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  operation,
    input  logic [COORD_W-1:0]    site_col,
    input  logic [COORD_W-1:0]    site_row,
    input  logic [COIN_BITS-1:0]  coin,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic                  accepted,
    output logic [ST_W-1:0]       status_code,
    output logic [H_W-1:0]        site_height,
    output logic [TOTAL_W-1:0]    cube_total
);

    cfg_t                 cfg_reg;
    logic                 op_reg;
    logic [COORD_W-1:0]   col_reg;
    logic [COORD_W-1:0]   row_reg;
    logic [COIN_BITS-1:0] coin_reg;
    logic                 add_reg;
    logic                 site_cut_reg;
    logic                 nbx_ok_reg;
    logic                 nby_ok_reg;
    logic [H_W-1:0]       h_reg;
    logic [H_W-1:0]       nbx_reg;
    logic [COORD_W-1:0]   sx_reg;
    logic [COORD_W-1:0]   sy_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic                 res_acc_reg;
    logic [ST_W-1:0]      res_st_reg;
    logic [H_W-1:0]       res_h_reg;
    logic                 out_acc_reg;
    logic [ST_W-1:0]      out_st_reg;
    logic [H_W-1:0]       out_h_reg;
    logic [TOTAL_W-1:0]   out_total_reg;

    logic [H_W-1:0]       mem [0:(1 << ADDR_W)-1];
    logic [H_W-1:0]       rdata_reg;
    logic [ADDR_W-1:0]    raddr;
    logic [ADDR_W-1:0]    waddr;
    logic [H_W-1:0]       wdata;
    logic                 we;

    logic [SIDE_W-1:0]    side_n;
    logic [SIDE_W-1:0]    col_w;
    logic [SIDE_W-1:0]    row_w;
    logic [SIDE_W-1:0]    sx_w;
    logic [SIDE_W-1:0]    sy_w;
    logic [H_W-1:0]       sweep_val;
    logic                 add_now;
    logic                 nbx_ok_now;
    logic                 nby_ok_now;
    logic                 dec_we;
    logic                 dec_acc;
    logic [ST_W-1:0]      dec_st;
    logic [H_W-1:0]       dec_h;
    logic [H_W-1:0]       sup_x;
    logic [H_W-1:0]       sup_y;

    // The usable side never exceeds the memory's side.
    assign side_n = (cfg_reg.grid_side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                             : cfg_reg.grid_side;
    assign col_w  = {1'b0, col_reg};
    assign row_w  = {1'b0, row_reg};
    assign sx_w   = {1'b0, sx_reg};
    assign sy_w   = {1'b0, sy_reg};

    assign status.is_clear   = (op_reg == OP_CLEAR);
    assign status.outside    = (col_w >= side_n) || (row_w >= side_n);
    assign status.grid_empty = (side_n == '0);
    assign status.sweep_last = (sx_w + 1'b1 == side_n) && (sy_w + 1'b1 == side_n);

    // Neighbor qualification: a missing or cutout neighbor never constrains.
    assign add_now = ({1'b0, coin_reg} < cfg_reg.add_threshold);
    always_comb
    begin
        if (add_now)
        begin
            nbx_ok_now = (col_reg != '0) && !in_cut(col_w - 1'b1, row_w, cfg_reg);
            nby_ok_now = (row_reg != '0) && !in_cut(col_w, row_w - 1'b1, cfg_reg);
        end
        else
        begin
            nbx_ok_now = (col_w + 1'b1 < side_n) && !in_cut(col_w + 1'b1, row_w, cfg_reg);
            nby_ok_now = (row_w + 1'b1 < side_n) && !in_cut(col_w, row_w + 1'b1, cfg_reg);
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NBX:  raddr = add_reg ? {row_reg, col_reg - 1'b1} : {row_reg, col_reg + 1'b1};
            RD_NBY:  raddr = add_reg ? {row_reg - 1'b1, col_reg} : {row_reg + 1'b1, col_reg};
            default: raddr = {row_reg, col_reg};
        endcase
    end

    // Flip decision; the up or down neighbor arrives on the read port this cycle.
    always_comb
    begin
        dec_we  = 1'b0;
        dec_acc = 1'b0;
        dec_st  = ST_FLIPPED;
        dec_h   = h_reg;
        sup_x   = '0;
        sup_y   = '0;
        if (site_cut_reg)
        begin
            dec_st = ST_OUTSIDE;
        end
        else if (add_reg)
        begin
            sup_x = nbx_ok_reg ? nbx_reg : cfg_reg.height_limit;
            sup_y = nby_ok_reg ? rdata_reg : cfg_reg.height_limit;
            if (h_reg >= cfg_reg.height_limit)
            begin
                dec_st = ST_LIMIT;
            end
            else if ((h_reg < sup_x) && (h_reg < sup_y))
            begin
                dec_we  = 1'b1;
                dec_acc = 1'b1;
                dec_h   = h_reg + 1'b1;
            end
            else
            begin
                dec_st = ST_BLOCKED;
            end
        end
        else
        begin
            sup_x = nbx_ok_reg ? nbx_reg : '0;
            sup_y = nby_ok_reg ? rdata_reg : '0;
            if (h_reg == '0)
            begin
                dec_st = ST_LIMIT;
            end
            else if ((h_reg > sup_x) && (h_reg > sup_y))
            begin
                dec_we  = 1'b1;
                dec_acc = 1'b1;
                dec_h   = h_reg - 1'b1;
            end
            else
            begin
                dec_st = ST_BLOCKED;
            end
        end
    end

    assign sweep_val = in_cut(sx_w, sy_w, cfg_reg) ? cfg_reg.hole_level : '0;

    always_comb
    begin
        total_next = total_reg;
        if (cmd.clr_start)
        begin
            total_next = '0;
        end
        else if (cmd.clr_step)
        begin
            total_next = total_reg + TOTAL_W'(sweep_val);
        end
        else if (cmd.decide && dec_we)
        begin
            total_next = add_reg ? total_reg + 1'b1 : total_reg - 1'b1;
        end
    end

    assign we    = cmd.clr_step || (cmd.decide && dec_we);
    assign waddr = cmd.clr_step ? {sy_reg, sx_reg} : {row_reg, col_reg};
    assign wdata = cmd.clr_step ? sweep_val : dec_h;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_side     <= SIDE_W'(60);
            cfg_reg.height_limit  <= H_W'(42);
            cfg_reg.cut_col_lo    <= SIDE_W'(18);
            cfg_reg.cut_col_hi    <= SIDE_W'(36);
            cfg_reg.cut_row_lo    <= SIDE_W'(15);
            cfg_reg.cut_row_hi    <= SIDE_W'(45);
            cfg_reg.hole_level    <= '0;
            cfg_reg.add_threshold <= THR_W'(32768);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_SIDE:     cfg_reg.grid_side     <= cfg_data[SIDE_W-1:0];
                REG_HEIGHT_LIMIT:  cfg_reg.height_limit  <= cfg_data[H_W-1:0];
                REG_CUT_COL_LO:    cfg_reg.cut_col_lo    <= cfg_data[SIDE_W-1:0];
                REG_CUT_COL_HI:    cfg_reg.cut_col_hi    <= cfg_data[SIDE_W-1:0];
                REG_CUT_ROW_LO:    cfg_reg.cut_row_lo    <= cfg_data[SIDE_W-1:0];
                REG_CUT_ROW_HI:    cfg_reg.cut_row_hi    <= cfg_data[SIDE_W-1:0];
                REG_HOLE_LEVEL:    cfg_reg.hole_level    <= cfg_data[H_W-1:0];
                REG_ADD_THRESHOLD: cfg_reg.add_threshold <= cfg_data[THR_W-1:0];
                default:           cfg_reg.grid_side     <= cfg_reg.grid_side;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
        end
        else
        begin
            total_reg <= total_next;
            if (cmd.clr_start || (cmd.clr_step && status.sweep_last))
            begin
                sx_reg <= '0;
                sy_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                if (sx_w + 1'b1 == side_n)
                begin
                    sx_reg <= '0;
                    sy_reg <= sy_reg + 1'b1;
                end
                else
                begin
                    sx_reg <= sx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= operation;
            col_reg  <= site_col;
            row_reg  <= site_row;
            coin_reg <= coin;
        end
        if (cmd.check)
        begin
            add_reg      <= add_now;
            site_cut_reg <= in_cut(col_w, row_w, cfg_reg);
            nbx_ok_reg   <= nbx_ok_now;
            nby_ok_reg   <= nby_ok_now;
        end
        if (cmd.lat_h)
        begin
            h_reg <= rdata_reg;
        end
        if (cmd.lat_nbx)
        begin
            nbx_reg <= rdata_reg;
        end
        if (cmd.res_outside)
        begin
            res_acc_reg <= 1'b0;
            res_st_reg  <= ST_OUTSIDE;
            res_h_reg   <= '0;
        end
        else if (cmd.res_clear)
        begin
            res_acc_reg <= 1'b0;
            res_st_reg  <= ST_CLEARED;
            res_h_reg   <= '0;
        end
        else if (cmd.decide)
        begin
            res_acc_reg <= dec_acc;
            res_st_reg  <= dec_st;
            res_h_reg   <= dec_h;
        end
        if (cmd.load_out)
        begin
            out_acc_reg   <= res_acc_reg;
            out_st_reg    <= res_st_reg;
            out_h_reg     <= res_h_reg;
            out_total_reg <= total_reg;
        end
    end

    assign accepted    = out_acc_reg;
    assign status_code = out_st_reg;
    assign site_height = out_h_reg;
    assign cube_total  = out_total_reg;

endmodule

// ----- hdl/lozenge_tiling_glauber_flip.sv -----
// Top level of the lozenge tiling flip engine: port wiring, sequencer, datapath and checks.

// A step word goes through the check, neighbor read and decide states to the finish state,
// which loads its result into the output registers once the output no longer stalls on an
// earlier result. The single read port of the height memory sets this: it reads the site
// and then its two neighbors one after the other before the write-back. A clear word
// sweeps the N x N grid one cell a cycle, and its result is loaded once the sweep ends, or
// straight after the check when the grid side is zero. A new word is taken once the
// previous one has left its datapath, even while its result still waits on the output.
// The height memory holds nothing meaningful until a clear has covered it, so a clear
// must come before the first step. Configuration registers are always ready and must be
// written only while the engine is idle.
module lozenge_tiling_glauber_flip
    import lzg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [COORD_W-1:0]    site_col,
    input  logic [COORD_W-1:0]    site_row,
    input  logic [COIN_BITS-1:0]  coin,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  accepted,
    output logic [ST_W-1:0]       status,
    output logic [H_W-1:0]        site_height,
    output logic [TOTAL_W-1:0]    cube_total
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    lzg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (dp_status),
        .cmd       (cmd)
    );

    lzg_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .operation   (operation),
        .site_col    (site_col),
        .site_row    (site_row),
        .coin        (coin),
        .cmd         (cmd),
        .status      (dp_status),
        .accepted    (accepted),
        .status_code (status),
        .site_height (site_height),
        .cube_total  (cube_total)
    );

    // Only one word is in the datapath at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word accepted while one is in the datapath");

    // A result word is loaded only after the sequencer has left the idle state.
    a_load_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> in_stall)
        else $error("result loaded with no word in the datapath");

    // On a valid result, the accepted flag and the flipped status always agree.
    a_flag_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (status == ST_FLIPPED)))
        else $error("accepted flag disagrees with status");

    // A cleared result reports a zero height.
    a_clear_height: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_CLEARED)) |-> (site_height == '0))
        else $error("cleared result with a nonzero height");

endmodule
